// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the overlap test block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked at every clock edge out of reset
`define OBB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition must never hold out of reset
`define OBB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/obb_pkg.sv -----
package obb_pkg;

  localparam int CoordW  = 20;
  localparam int LinW    = 16;
  localparam int LinFrac = LinW - 2;
  localparam int NumAxes = 15;

  // axis entries: 0, 1, a linear entry or its negation
  localparam int AxisW  = LinW + 1;
  localparam int ProdLW = AxisW + LinW;
  localparam int BW     = ProdLW + 2;
  localparam int OwnPW  = AxisW + CoordW;
  localparam int OwnSW  = OwnPW + 2;
  localparam int QW     = BW + CoordW;
  localparam int SumW   = QW + 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [LinW-1:0]   lin_t;
  typedef logic signed [AxisW-1:0]  axis_t;
  typedef axis_t [2:0]              axis_vec_t;

  typedef enum logic [2:0] {
    REG_OWN_MIN_X = 3'd0,
    REG_OWN_MIN_Y = 3'd1,
    REG_OWN_MIN_Z = 3'd2,
    REG_OWN_MAX_X = 3'd3,
    REG_OWN_MAX_Y = 3'd4,
    REG_OWN_MAX_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    coord_t [2:0]      own_min;
    coord_t [2:0]      own_max;
    coord_t [2:0]      oth_min;
    coord_t [2:0]      oth_max;
    coord_t [2:0]      trans;
    lin_t [2:0][2:0]   lin;      // lin[row][col]
  } operand_t;

  // axis k: frame axes, linear columns, then frame axis u cross column j
  function automatic axis_vec_t axis_of(input int k, input lin_t [2:0][2:0] lin);
    axis_vec_t v;
    axis_t     c0;
    axis_t     c1;
    axis_t     c2;
    int        u;
    int        j;
    v = '0;
    u = 0;
    j = 0;
    if (k < 3) begin
      v[k] = axis_t'(1);
    end else if (k < 6) begin
      for (int r = 0; r < 3; r++) begin
        v[r] = axis_t'($signed(lin[r][k-3]));
      end
    end else begin
      j = k - 6;
      if (j >= 3) begin
        u = 1;
        j = j - 3;
      end
      if (j >= 3) begin
        u = 2;
        j = j - 3;
      end
      c0 = axis_t'($signed(lin[0][j]));
      c1 = axis_t'($signed(lin[1][j]));
      c2 = axis_t'($signed(lin[2][j]));
      if (u == 0) begin
        v[1] = -c2;
        v[2] = c1;
      end else if (u == 1) begin
        v[0] = c2;
        v[2] = -c0;
      end else begin
        v[0] = -c1;
        v[1] = c0;
      end
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/obb_obb_overlap_test.sv -----
// done_o strobes when stage 7 registers the overlap result of an accepted box pair
// throughput: one box pair per cycle; busy_o stays low, the pipeline never stalls
// results cannot be held off by the receiver, so no backpressure path exists
// reset: rst_ni async active low, clears valid bits and the reference box to 0
`include "assert_macros.svh"

module obb_obb_overlap_test import obb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [3*CoordW-1:0]   other_min_xyz_i,
  input  logic [3*CoordW-1:0]   other_max_xyz_i,
  input  logic [3*LinW-1:0]     linear_row0_i,
  input  logic [3*LinW-1:0]     linear_row1_i,
  input  logic [3*LinW-1:0]     linear_row2_i,
  input  logic [3*CoordW-1:0]   translation_xyz_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CoordW-1:0]     cfg_wdata_i,
  output logic                  done_o,
  output logic                  boxes_overlap_o
);

  // reference box registers
  coord_t own_min_q [3];
  coord_t own_max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        own_min_q[c] <= '0;
        own_max_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_MIN_X: own_min_q[0] <= cfg_wdata_i;
        REG_OWN_MIN_Y: own_min_q[1] <= cfg_wdata_i;
        REG_OWN_MIN_Z: own_min_q[2] <= cfg_wdata_i;
        REG_OWN_MAX_X: own_max_q[0] <= cfg_wdata_i;
        REG_OWN_MAX_Y: own_max_q[1] <= cfg_wdata_i;
        REG_OWN_MAX_Z: own_max_q[2] <= cfg_wdata_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // no stall anywhere, a new word can enter every cycle
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: unpack the incoming word and snapshot the reference box
  operand_t op_d, op_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      op_d.own_min[c] = own_min_q[c];
      op_d.own_max[c] = own_max_q[c];
      op_d.oth_min[c] = other_min_xyz_i[c*CoordW +: CoordW];
      op_d.oth_max[c] = other_max_xyz_i[c*CoordW +: CoordW];
      op_d.trans[c]   = translation_xyz_i[c*CoordW +: CoordW];
      op_d.lin[0][c]  = linear_row0_i[c*LinW +: LinW];
      op_d.lin[1][c]  = linear_row1_i[c*LinW +: LinW];
      op_d.lin[2][c]  = linear_row2_i[c*LinW +: LinW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  // valid bits for stages 1 through 6
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // one lane per candidate axis; axis vectors are unit vectors, linear columns or sign flips of linear entries
  logic [NumAxes-1:0] sep;

  for (genvar k = 0; k < NumAxes; k++) begin : g_lane
    axis_vec_t axis;
    assign axis = axis_of(k, op_q.lin);
    obb_lane u_lane (
      .clk_i (clk_i),
      .a_i   (axis),
      .op_i  (op_q),
      .sep_o (sep[k])
    );
  end

  // stage 7: any separating axis clears the overlap flag
  logic done_q;
  logic ovl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[5]) begin
      ovl_q <= ~|sep;
    end
  end

  assign done_o          = done_q;
  assign boxes_overlap_o = ovl_q;

  // every accepted word gives exactly one strobe, and every strobe traces back to an accepted word
  `OBB_ASSERT_IMPL(a_accept_done, accept, ##7 done_o)
  `OBB_ASSERT_IMPL(a_done_origin, done_o, $past(accept, 7))
  `OBB_ASSERT_NEVER(a_never_busy, busy_o)

endmodule

// ----- hw/rtl/obb_lane.sv -----
module obb_lane import obb_pkg::*; (
  input  logic      clk_i,
  input  axis_vec_t a_i,
  input  operand_t  op_i,
  output logic      sep_o
);

  // stage 2: products with the axis
  logic signed [ProdLW-1:0] pr_q [3][3];
  logic signed [OwnPW-1:0]  pmin_q [3];
  logic signed [OwnPW-1:0]  pmax_q [3];
  logic signed [OwnPW-1:0]  pt_q [3];
  coord_t                   omin2_q [3];
  coord_t                   omax2_q [3];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pr_q[r][c] <= ProdLW'($signed(a_i[r]) * $signed(op_i.lin[r][c]));
      end
      pmin_q[r]  <= OwnPW'($signed(a_i[r]) * $signed(op_i.own_min[r]));
      pmax_q[r]  <= OwnPW'($signed(a_i[r]) * $signed(op_i.own_max[r]));
      pt_q[r]    <= OwnPW'($signed(a_i[r]) * $signed(op_i.trans[r]));
      omin2_q[r] <= op_i.oth_min[r];
      omax2_q[r] <= op_i.oth_max[r];
    end
  end

  // stage 3: axis in other frame, own interval, translation term
  logic signed [BW-1:0]    b_d [3];
  logic signed [BW-1:0]    b_q [3];
  logic signed [OwnSW-1:0] lo1_d, hi1_d, at_d;
  logic signed [OwnSW-1:0] lo1_q, hi1_q, at_q;
  coord_t                  omin3_q [3];
  coord_t                  omax3_q [3];

  always_comb begin
    lo1_d = '0;
    hi1_d = '0;
    at_d  = '0;
    for (int c = 0; c < 3; c++) begin
      b_d[c] = BW'(pr_q[0][c]) + BW'(pr_q[1][c]) + BW'(pr_q[2][c]);
      if (pmin_q[c] < pmax_q[c]) begin
        lo1_d = lo1_d + OwnSW'(pmin_q[c]);
        hi1_d = hi1_d + OwnSW'(pmax_q[c]);
      end else begin
        lo1_d = lo1_d + OwnSW'(pmax_q[c]);
        hi1_d = hi1_d + OwnSW'(pmin_q[c]);
      end
      at_d = at_d + OwnSW'(pt_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      b_q[c]     <= b_d[c];
      omin3_q[c] <= omin2_q[c];
      omax3_q[c] <= omax2_q[c];
    end
    lo1_q <= lo1_d;
    hi1_q <= hi1_d;
    at_q  <= at_d;
  end

  // stage 4: other box corner terms
  logic signed [QW-1:0]    qmin_q [3];
  logic signed [QW-1:0]    qmax_q [3];
  logic signed [OwnSW-1:0] lo1_4_q, hi1_4_q, at_4_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      qmin_q[c] <= QW'($signed(b_q[c]) * $signed(omin3_q[c]));
      qmax_q[c] <= QW'($signed(b_q[c]) * $signed(omax3_q[c]));
    end
    lo1_4_q <= lo1_q;
    hi1_4_q <= hi1_q;
    at_4_q  <= at_q;
  end

  // stage 5: both intervals at common scale
  logic signed [SumW-1:0] lo2_d, hi2_d;
  logic signed [SumW-1:0] lo2_q, hi2_q, lo1_5_q, hi1_5_q;

  always_comb begin
    lo2_d = SumW'(at_4_q) <<< LinFrac;
    hi2_d = SumW'(at_4_q) <<< LinFrac;
    for (int c = 0; c < 3; c++) begin
      if (qmin_q[c] < qmax_q[c]) begin
        lo2_d = lo2_d + SumW'(qmin_q[c]);
        hi2_d = hi2_d + SumW'(qmax_q[c]);
      end else begin
        lo2_d = lo2_d + SumW'(qmax_q[c]);
        hi2_d = hi2_d + SumW'(qmin_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo2_q   <= lo2_d;
    hi2_q   <= hi2_d;
    lo1_5_q <= SumW'(lo1_4_q) <<< LinFrac;
    hi1_5_q <= SumW'(hi1_4_q) <<< LinFrac;
  end

  // stage 6: disjoint intervals mean a separating axis
  logic sep_q;

  always_ff @(posedge clk_i) begin
    sep_q <= (hi1_5_q < lo2_q) || (hi2_q < lo1_5_q);
  end

  assign sep_o = sep_q;

endmodule

// ----- dv/obb_obb_overlap_test_checker.sv -----
`timescale 1ns / 100ps

module obb_obb_overlap_test_checker import obb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [3*CoordW-1:0] other_min_xyz_i,
  input  logic [3*CoordW-1:0] other_max_xyz_i,
  input  logic [3*LinW-1:0]   linear_row0_i,
  input  logic [3*LinW-1:0]   linear_row1_i,
  input  logic [3*LinW-1:0]   linear_row2_i,
  input  logic [3*CoordW-1:0] translation_xyz_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_wdata_i,
  input  logic                done_o,
  input  logic                boxes_overlap_o,
  output int                  pending_o,
  output int                  fail_count_o
);

  typedef logic signed [127:0] wide_t;

  coord_t ref_box[6];
  bit     overlap_q[$];

  function automatic wide_t dot3(input longint c[3], input longint a[3]);
    wide_t s;
    wide_t x;
    wide_t y;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      x = c[i];
      y = a[i];
      s = s + x * y;
    end
    return s;
  endfunction

  function automatic bit predict_overlap(input coord_t box[6],
                                         input logic [3*CoordW-1:0] omin,
                                         input logic [3*CoordW-1:0] omax,
                                         input logic [3*LinW-1:0] r0,
                                         input logic [3*LinW-1:0] r1,
                                         input logic [3*LinW-1:0] r2,
                                         input logic [3*CoordW-1:0] tr);
    logic [3*LinW-1:0] rows[3];
    longint lin[3][3];
    longint lo_c[3];
    longint hi_c[3];
    longint tv[3];
    longint p[3];
    longint own_c[8][3];
    longint oth_c[8][3];
    longint ax[15][3];
    longint u[3];
    longint v[3];
    wide_t  pr;
    wide_t  lo1;
    wide_t  hi1;
    wide_t  lo2;
    wide_t  hi2;
    bit     ok;
    rows[0] = r0;
    rows[1] = r1;
    rows[2] = r2;
    for (int c = 0; c < 3; c++) begin
      lo_c[c] = $signed(omin[c*CoordW +: CoordW]);
      hi_c[c] = $signed(omax[c*CoordW +: CoordW]);
      tv[c] = longint'($signed(tr[c*CoordW +: CoordW])) <<< LinFrac;
      for (int r = 0; r < 3; r++) begin
        lin[r][c] = $signed(rows[r][c*LinW +: LinW]);
      end
    end
    // corner i picks min/max by bits 2,1,0 for x,y,z
    for (int i = 0; i < 8; i++) begin
      own_c[i][0] = longint'(box[((i >> 2) & 1) * 3 + 0]) <<< LinFrac;
      own_c[i][1] = longint'(box[((i >> 1) & 1) * 3 + 1]) <<< LinFrac;
      own_c[i][2] = longint'(box[(i & 1) * 3 + 2]) <<< LinFrac;
      p[0] = ((i >> 2) & 1) ? hi_c[0] : lo_c[0];
      p[1] = ((i >> 1) & 1) ? hi_c[1] : lo_c[1];
      p[2] = (i & 1) ? hi_c[2] : lo_c[2];
      for (int r = 0; r < 3; r++) begin
        oth_c[i][r] = lin[r][0] * p[0] + lin[r][1] * p[1] + lin[r][2] * p[2] + tv[r];
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        ax[k][r] = (r == k) ? 1 : 0;
        ax[3+k][r] = lin[r][k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        u = ax[k];
        v = ax[3+c];
        ax[6+3*k+c][0] = u[1] * v[2] - u[2] * v[1];
        ax[6+3*k+c][1] = u[2] * v[0] - u[0] * v[2];
        ax[6+3*k+c][2] = u[0] * v[1] - u[1] * v[0];
      end
    end
    ok = 1'b1;
    for (int k = 0; k < NumAxes; k++) begin
      lo1 = dot3(own_c[0], ax[k]);
      hi1 = lo1;
      lo2 = dot3(oth_c[0], ax[k]);
      hi2 = lo2;
      for (int i = 1; i < 8; i++) begin
        pr = dot3(own_c[i], ax[k]);
        if (pr < lo1) lo1 = pr;
        if (pr > hi1) hi1 = pr;
        pr = dot3(oth_c[i], ax[k]);
        if (pr < lo2) lo2 = pr;
        if (pr > hi2) hi2 = pr;
      end
      // touching intervals still overlap
      if (hi1 < lo2 || hi2 < lo1) ok = 1'b0;
    end
    return ok;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) ref_box[i] <= '0;
      overlap_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_OWN_MAX_Z) begin
        ref_box[cfg_idx_i] <= cfg_wdata_i;
      end
      if (done_o) begin
        if (overlap_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result word %0b", boxes_overlap_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = overlap_q.pop_front();
          if (want !== boxes_overlap_o) begin
            if (fail_count_o < 10) begin
              $display("boxes_overlap mismatch: expected %0b actual %0b", want,
                       boxes_overlap_o);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_o) begin
        overlap_q.push_back(predict_overlap(ref_box, other_min_xyz_i, other_max_xyz_i,
                                            linear_row0_i, linear_row1_i, linear_row2_i,
                                            translation_xyz_i));
      end
    end
  end

  assign pending_o = overlap_q.size();

endmodule

// ----- dv/obb_obb_overlap_test_test.sv -----
`timescale 1ns / 100ps

module obb_obb_overlap_test_test;
  import obb_pkg::*;

  localparam logic [2:0] CfgIdxSpare0 = 3'd6;  // not a register, write is dropped
  localparam logic [2:0] CfgIdxSpare1 = 3'd7;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 12;   // extra wait after the last expected result

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [3*CoordW-1:0] other_min_xyz_i = '0;
  logic [3*CoordW-1:0] other_max_xyz_i = '0;
  logic [3*LinW-1:0]   linear_row0_i = '0;
  logic [3*LinW-1:0]   linear_row1_i = '0;
  logic [3*LinW-1:0]   linear_row2_i = '0;
  logic [3*CoordW-1:0] translation_xyz_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [CoordW-1:0]   cfg_wdata_i = '0;
  logic                done_o;
  logic                boxes_overlap_o;
  int                  pending;
  int                  fail_count;
  int                  idle_pct;
  int                  quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  obb_obb_overlap_test DUT (.*);

  obb_obb_overlap_test_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_o, .other_min_xyz_i, .other_max_xyz_i,
    .linear_row0_i, .linear_row1_i, .linear_row2_i, .translation_xyz_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .boxes_overlap_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // watchdog: cycles with no accepted word, no result, no register write and no reset
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("obb_obb_overlap_test_test NOT OK");
        $finish;
      end
    end
  end

  // mostly small coordinates so boxes meet often, sometimes any bit pattern
  function automatic coord_t rnd_coord();
    if ($urandom_range(0, 99) < 20) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic lin_t rnd_lin();
    if ($urandom_range(0, 99) < 25) return lin_t'($urandom);
    return lin_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [3*CoordW-1:0] rnd_pos3();
    return {rnd_coord(), rnd_coord(), rnd_coord()};
  endfunction

  function automatic logic [3*LinW-1:0] rnd_row();
    return {rnd_lin(), rnd_lin(), rnd_lin()};
  endfunction

  // reference box: six writes back to back, plus the two unused indexes
  task automatic write_ref_box(input coord_t box[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_idx_e'(i);
      cfg_wdata_i <= box[i];
      @(posedge clk_i);
    end
    cfg_idx_i <= CfgIdxSpare0;
    cfg_wdata_i <= coord_t'($urandom);
    @(posedge clk_i);
    cfg_idx_i <= CfgIdxSpare1;
    cfg_wdata_i <= coord_t'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one word, with a random gap before it; waits for the accepting edge
  task automatic send_word(input logic [3*CoordW-1:0] omin, input logic [3*CoordW-1:0] omax,
                           input logic [3*LinW-1:0] r0, input logic [3*LinW-1:0] r1,
                           input logic [3*LinW-1:0] r2, input logic [3*CoordW-1:0] tr);
    logic b;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    start_i <= 1'b1;
    other_min_xyz_i <= omin;
    other_max_xyz_i <= omax;
    linear_row0_i <= r0;
    linear_row1_i <= r1;
    linear_row2_i <= r2;
    translation_xyz_i <= tr;
    forever begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
      if (!b) break;
    end
  endtask

  // let every expected word come back before touching the registers
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_words(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(rnd_pos3(), rnd_pos3(), rnd_row(), rnd_row(), rnd_row(), rnd_pos3());
    end
  endtask

  localparam logic [3*LinW-1:0] RowX = {16'sd0, 16'sd0, 16'sd16384};
  localparam logic [3*LinW-1:0] RowY = {16'sd0, 16'sd16384, 16'sd0};
  localparam logic [3*LinW-1:0] RowZ = {16'sd16384, 16'sd0, 16'sd0};

  initial begin
    coord_t box[6];
    logic [3*CoordW-1:0] c256;
    idle_pct = 19;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reference box: cube from 0 to 256
    box = '{0, 0, 0, 256, 256, 256};
    write_ref_box(box);
    c256 = {20'sd256, 20'sd256, 20'sd256};
    // identity, coincident box
    send_word('0, c256, RowX, RowY, RowZ, '0);
    // touching faces along x
    send_word('0, c256, RowX, RowY, RowZ, {20'sd0, 20'sd0, 20'sd256});
    // just apart along x
    send_word('0, c256, RowX, RowY, RowZ, {20'sd0, 20'sd0, 20'sd257});
    // min above max acts like the spanned box
    send_word(c256, '0, RowX, RowY, RowZ, '0);
    // singular transform collapses to the translation point
    send_word('0, c256, '0, '0, '0, {20'sd128, 20'sd128, 20'sd128});
    send_word('0, c256, '0, '0, '0, {20'sd1000, 20'sd128, 20'sd128});
    // rotated 90 degrees about z; six of the nine cross-product axes are nonzero
    send_word('0, c256, {16'sd0, -16'sd16384, 16'sd0}, RowX, RowZ, '0);
    // field extremes
    send_word('1, '1, '1, '1, '1, '1);
    send_word({3{20'h80000}}, {3{20'h7ffff}}, {3{16'h8000}}, {3{16'h7fff}},
              {3{16'h8000}}, {3{20'h80000}});
    send_word({3{20'h7ffff}}, {3{20'h80000}}, {3{16'h7fff}}, {3{16'h8000}},
              {3{16'h7fff}}, {3{20'h7ffff}});
    send_word('0, '0, '0, '0, '0, '0);
    random_words(233);
    drain();

    // widest possible reference box
    idle_pct = 67;
    box = '{-524288, -524288, -524288, 524287, 524287, 524287};
    write_ref_box(box);
    send_word({3{20'h80000}}, {3{20'h7ffff}}, {3{16'h7fff}}, {3{16'h7fff}},
              {3{16'h7fff}}, {3{20'h7ffff}});
    random_words(233);
    drain();

    // random box, possibly inverted
    idle_pct = 0;
    for (int i = 0; i < 6; i++) box[i] = rnd_coord();
    write_ref_box(box);
    random_words(234);
    drain();

    if (fail_count == 0) begin
      $display("obb_obb_overlap_test_test OK");
    end else begin
      $display("obb_obb_overlap_test_test NOT OK");
    end
    $finish;
  end

endmodule
